FILE: rtl/core/skvt_pkg.sv
package skvt_pkg;

  // field widths of the request and result
  localparam int FUNC_W = 2;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int POS_W  = 7;

  // default table depth
  localparam int CAPACITY_DEF = 64;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // latch request, open the search range
    logic probe;     // take midpoint, read it
    logic compare;   // narrow the range on the read key
    logic setup;     // load the shift index
    logic shift_wr;  // write the moved entry, step the index
    logic put;       // write the new entry at its slot
    logic finish;    // post the result, update the count
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic range_open;  // search still has candidates
    logic do_ins;      // insert will change the table
    logic do_rem;      // remove will change the table
    logic is_ins;      // request is an insert
    logic more;        // another entry has to move
  } sts_t;

endpackage

FILE: rtl/core/skvt_ram.sv
module skvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/skvt_ctrl.sv
module skvt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  skvt_pkg::sts_t sts,
  output skvt_pkg::cmd_t cmd,
  output logic          busy
);

  import skvt_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PROBE  = 8'b0000_0010,
    S_CMP    = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_SH_RD  = 8'b0001_0000,
    S_SH_WR  = 8'b0010_0000,
    S_PUT    = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts.range_open) begin
          cmd.probe  = 1'b1;
          state_next = S_CMP;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_next  = S_PROBE;
      end
      S_DECIDE: begin
        cmd.setup = 1'b1;
        if (sts.do_ins || sts.do_rem) begin
          state_next = S_SH_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      // source entry is read here, written back in the next cycle
      S_SH_RD: begin
        if (sts.more) begin
          state_next = S_SH_WR;
        end else if (sts.is_ins) begin
          state_next = S_PUT;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SH_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SH_RD;
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: rtl/core/skvt_dp.sv
module skvt_dp #(
  parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  skvt_pkg::cmd_t                    cmd,
  output skvt_pkg::sts_t                    sts,
  input  logic [skvt_pkg::FUNC_W-1:0]       func,
  input  logic signed [skvt_pkg::KEY_W-1:0] key,
  input  logic [skvt_pkg::VAL_W-1:0]        value,
  output logic                              done,
  output logic [skvt_pkg::STAT_W-1:0]       status,
  output logic [skvt_pkg::VAL_W-1:0]        found_value,
  output logic [skvt_pkg::POS_W-1:0]        position,
  output logic [skvt_pkg::POS_W-1:0]        entry_count
);

  import skvt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // request and search registers
  logic [FUNC_W-1:0]       func_r;
  logic signed [KEY_W-1:0] key_r;
  logic [VAL_W-1:0]        val_r;
  logic [CNT_W-1:0]        lo, hi, mid, idx, count;
  logic                    hit;
  logic [VAL_W-1:0]        found;

  logic [CNT_W:0]          sum;
  logic [CNT_W-1:0]        mid_calc;
  logic                    is_ins, is_rem, full;
  logic                    we;
  logic [AW-1:0]           raddr, waddr;
  logic [KEY_W-1:0]        wkey, rkey;
  logic [VAL_W-1:0]        wval, rval;

  // midpoint of the open range
  assign sum      = (CNT_W+1)'(lo) + (CNT_W+1)'(hi);
  assign mid_calc = sum[CNT_W:1];

  assign is_ins = (func_r == FUNC_INSERT);
  assign is_rem = (func_r == FUNC_REMOVE);
  assign full   = (count == CNT_W'(CAPACITY));

  // status to the controller
  always_comb begin
    sts.range_open = (lo < hi) && !hit;
    sts.do_ins     = is_ins && !hit && !full;
    sts.do_rem     = is_rem && hit;
    sts.is_ins     = is_ins;
    sts.more       = is_ins ? (idx > lo)
                            : ((CNT_W+1)'(idx) + 1'b1 < (CNT_W+1)'(count));
  end

  // memory addressing: probe or shift source, shift target or new slot
  always_comb begin
    if (cmd.probe) begin
      raddr = AW'(mid_calc);
    end else if (is_ins) begin
      raddr = AW'(idx - 1'b1);
    end else begin
      raddr = AW'(idx + 1'b1);
    end
    we    = cmd.shift_wr | cmd.put;
    waddr = cmd.put ? AW'(lo) : AW'(idx);
    wkey  = cmd.put ? key_r : rkey;
    wval  = cmd.put ? val_r : rval;
  end

  skvt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_key_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wkey),
    .raddr (raddr),
    .rdata (rkey)
  );

  skvt_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_val_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wval),
    .raddr (raddr),
    .rdata (rval)
  );

  // request, search and shift registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      key_r  <= key;
      val_r  <= value;
      lo     <= '0;
      hi     <= count;
      hit    <= 1'b0;
      found  <= '0;
    end
    if (cmd.probe) begin
      mid <= mid_calc;
    end
    if (cmd.compare) begin
      if (key_r == $signed(rkey)) begin
        hit   <= 1'b1;
        lo    <= mid;
        found <= rval;
      end else if (key_r < $signed(rkey)) begin
        hi <= mid;
      end else begin
        lo <= mid + 1'b1;
      end
    end
    if (cmd.setup) begin
      idx <= is_ins ? count : lo;
    end
    if (cmd.shift_wr) begin
      idx <= is_ins ? idx - 1'b1 : idx + 1'b1;
    end
  end

  // result registers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish) begin
        if (sts.do_ins) begin
          count <= count + 1'b1;
        end else if (sts.do_rem) begin
          count <= count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      position    <= POS_W'(lo);
      found_value <= '0;
      if (is_ins) begin
        entry_count <= sts.do_ins ? POS_W'(count + 1'b1) : POS_W'(count);
        if (hit) begin
          status <= ST_DUP;
        end else if (full) begin
          status <= ST_FULL;
        end else begin
          status <= ST_OK;
        end
      end else if (is_rem) begin
        entry_count <= hit ? POS_W'(count - 1'b1) : POS_W'(count);
        status      <= hit ? ST_OK : ST_MISS;
      end else begin
        entry_count <= POS_W'(count);
        status      <= hit ? ST_OK : ST_MISS;
        if (hit) begin
          found_value <= found;
        end
      end
    end
  end

endmodule

FILE: rtl/core/sorted_key_value_table_core.sv
// sequence: a binary search of p probes (at most log2(entries)+1), each a probe and a compare,
// then for an insert or remove that changes the table m entries moved, each read in S_SH_RD
// and written in S_SH_WR; an insert then writes the new entry in S_PUT; the result is posted in S_FIN
// throughput: one request at a time, the next start is taken in the cycle that done is shown
// the result is shown for one cycle with done; the receiver cannot stall it
// reset: synchronous; empties the table at once (no clearing pass), RAM contents are kept
module sorted_key_value_table_core #(
  parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [skvt_pkg::FUNC_W-1:0]       func,
  input  logic signed [skvt_pkg::KEY_W-1:0] key,
  input  logic [skvt_pkg::VAL_W-1:0]        value,
  output logic                              done,
  output logic [skvt_pkg::STAT_W-1:0]       status,
  output logic [skvt_pkg::VAL_W-1:0]        found_value,
  output logic [skvt_pkg::POS_W-1:0]        position,
  output logic [skvt_pkg::POS_W-1:0]        entry_count
);

  import skvt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  skvt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // search, shift and result datapath
  skvt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .func        (func),
    .key         (key),
    .value       (value),
    .done        (done),
    .status      (status),
    .found_value (found_value),
    .position    (position),
    .entry_count (entry_count)
  );

  // a transfer starts the sequencer
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // the result strobe comes back in idle and lasts one cycle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy ##1 !done)
    else $error("result strobe not a single idle cycle");

  // a full refusal reports a full table
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (entry_count == POS_W'(CAPACITY)))
    else $error("full status with table not full");

  // only a successful request carries a found value
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (done && found_value != '0) |-> (status == ST_OK))
    else $error("found value on a failed request");

endmodule

FILE: tb/sorted_key_value_table_core_tb.sv
module sorted_key_value_table_core_tb;
  import skvt_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int POOL_N     = 32;

  // unused operation code, handled as a lookup
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  // shadow of the table: predicts each result and holds the ones still due
  class table_scoreboard;
    typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [VAL_W-1:0]  found_value;
      logic [POS_W-1:0]  position;
      logic [POS_W-1:0]  entry_count;
    } table_result_t;

    logic signed [KEY_W-1:0] keys[CAP];
    logic [VAL_W-1:0]        vals[CAP];
    int                      fill;
    table_result_t           due_results[$];
    int                      errors;
    int                      peak_fill;
    int                      func_seen[4];
    int                      status_seen[4];

    function new();
      fill      = 0;
      errors    = 0;
      peak_fill = 0;
      foreach (func_seen[i]) func_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // binary search over the sorted keys; slot is the hit or the insertion index
    function void search(input logic signed [KEY_W-1:0] k, output bit hit, output int slot);
      int lo;
      int hi;
      int mid;
      lo  = 0;
      hi  = fill;
      hit = 0;
      slot = 0;
      while (lo < hi && !hit) begin
        mid = (lo + hi) >> 1;
        if (k < keys[mid]) begin
          hi = mid;
        end else if (k > keys[mid]) begin
          lo = mid + 1;
        end else begin
          hit  = 1;
          slot = mid;
        end
      end
      if (!hit) slot = lo;
    endfunction

    // apply one accepted request to the shadow and queue its result
    function void note_request(input logic [FUNC_W-1:0] f, input logic signed [KEY_W-1:0] k,
                               input logic [VAL_W-1:0] v);
      bit            hit;
      int            slot;
      table_result_t r;
      search(k, hit, slot);
      r.found_value = '0;
      if (f == FUNC_INSERT) begin
        if (hit) begin
          r.status = ST_DUP;
        end else if (fill >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (int i = fill; i > slot; i--) begin
            keys[i] = keys[i-1];
            vals[i] = vals[i-1];
          end
          keys[slot] = k;
          vals[slot] = v;
          fill++;
          r.status = ST_OK;
        end
      end else if (f == FUNC_REMOVE) begin
        if (hit) begin
          for (int i = slot; i + 1 < fill; i++) begin
            keys[i] = keys[i+1];
            vals[i] = vals[i+1];
          end
          fill--;
          r.status = ST_OK;
        end else begin
          r.status = ST_MISS;
        end
      end else begin
        // lookup, and the unused code behaves the same
        if (hit) begin
          r.found_value = vals[slot];
          r.status      = ST_OK;
        end else begin
          r.status = ST_MISS;
        end
      end
      r.position    = POS_W'(slot);
      r.entry_count = POS_W'(fill);
      if (fill > peak_fill) peak_fill = fill;
      func_seen[f]++;
      status_seen[r.status]++;
      due_results.push_back(r);
    endfunction

    // compare one result against the oldest one due
    function void check_result(input logic [STAT_W-1:0] st, input logic [VAL_W-1:0] fv,
                               input logic [POS_W-1:0] pos, input logic [POS_W-1:0] cnt);
      table_result_t e;
      if (due_results.size() == 0) begin
        $error("result with none due: status %0d found_value %h position %0d entry_count %0d",
               st, fv, pos, cnt);
        errors++;
        return;
      end
      e = due_results.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (fv !== e.found_value) begin
        $error("found_value: expected %h, got %h", e.found_value, fv);
        errors++;
      end
      if (pos !== e.position) begin
        $error("position: expected %0d, got %0d", e.position, pos);
        errors++;
      end
      if (cnt !== e.entry_count) begin
        $error("entry_count: expected %0d, got %0d", e.entry_count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [FUNC_W-1:0]         func;
  logic signed [KEY_W-1:0]   key;
  logic [VAL_W-1:0]          value;
  logic                      done;
  logic [STAT_W-1:0]         status;
  logic [VAL_W-1:0]          found_value;
  logic [POS_W-1:0]          position;
  logic [POS_W-1:0]          entry_count;

  table_scoreboard         sb;
  logic signed [KEY_W-1:0] key_pool[POOL_N];
  bit                      burst_mode;
  int                      idle_cycles;

  sorted_key_value_table_core u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .key         (key),
    .value       (value),
    .done        (done),
    .status      (status),
    .found_value (found_value),
    .position    (position),
    .entry_count (entry_count)
  );

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // result check and stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(status, found_value, position, entry_count);
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("sorted_key_value_table_core_tb: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // sender gap: mostly short, some long, none in burst stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // keys from a small pool so hits are common, with some fully random ones
  function automatic logic signed [KEY_W-1:0] pool_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, POOL_N - 1)];
  endfunction

  function automatic logic signed [KEY_W-1:0] present_key();
    if (sb.fill == 0) return pool_key();
    return sb.keys[$urandom_range(0, sb.fill - 1)];
  endfunction

  // one request transfer, then an optional gap with junk on the fields
  task automatic send(input logic [FUNC_W-1:0] f, input logic signed [KEY_W-1:0] k,
                      input logic [VAL_W-1:0] v);
    int g;
    start <= 1'b1;
    func  <= f;
    key   <= k;
    value <= v;
    do @(posedge clk); while (busy);
    sb.note_request(f, k, v);
    g = pick_gap();
    if (g > 0) begin
      start <= 1'b0;
      func  <= FUNC_W'($urandom);
      key   <= $urandom;
      value <= $urandom;
      repeat (g) @(posedge clk);
    end
  endtask

  // hold off until every due result is back
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_mixed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      send(FUNC_INSERT, pool_key(), pick_value());
    end else if (r < 70) begin
      send(FUNC_LOOKUP, ($urandom_range(0, 1) == 1) ? present_key() : pool_key(), $urandom);
    end else if (r < 95) begin
      send(FUNC_REMOVE, ($urandom_range(0, 2) != 0) ? present_key() : pool_key(), $urandom);
    end else begin
      send(FUNC_SPARE, present_key(), $urandom);
    end
  endtask

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  initial begin
    sb          = new();
    idle_cycles = 0;
    burst_mode  = 0;
    rst         = 1'b1;
    start       = 1'b0;
    func        = '0;
    key         = '0;
    value       = '0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = -1;
    key_pool[3] = 0;
    key_pool[4] = 1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes of key and value, duplicate, miss and unused-code cases
    send(FUNC_LOOKUP, 0, 0);
    send(FUNC_REMOVE, 5, 0);
    send(FUNC_INSERT, KEY_MIN, 32'h0000_0000);
    send(FUNC_INSERT, KEY_MAX, 32'hFFFF_FFFF);
    send(FUNC_INSERT, 0, 32'hA5A5_5A5A);
    send(FUNC_INSERT, -1, 32'h0000_0001);
    send(FUNC_INSERT, 1, 32'h8000_0001);
    send(FUNC_INSERT, KEY_MIN, 32'h0000_0123);
    send(FUNC_LOOKUP, KEY_MIN, 32'hFFFF_FFFF);
    send(FUNC_LOOKUP, KEY_MAX, 0);
    send(FUNC_LOOKUP, -1, 0);
    send(FUNC_LOOKUP, 2, 0);
    send(FUNC_SPARE, 0, 0);
    send(FUNC_SPARE, 7, 0);
    send(FUNC_REMOVE, 0, 32'hFFFF_FFFF);
    send(FUNC_REMOVE, 0, 0);
    send(FUNC_LOOKUP, 1, 0);
    send(FUNC_REMOVE, KEY_MAX, 0);
    send(FUNC_REMOVE, KEY_MIN, 0);
    send(FUNC_LOOKUP, KEY_MIN, 0);
    send(FUNC_INSERT, KEY_MAX - 1, 32'h5A5A_A5A5);
    send(FUNC_REMOVE, -1, 0);
    send(FUNC_LOOKUP, 1, 0);
    drain();

    // mixed traffic on the key pool
    for (int i = 0; i < 110; i++) begin
      burst_mode = (i >= 40 && i < 60);
      send_mixed();
    end
    burst_mode = 0;
    drain();

    // fill the table, then hit it while full
    while (sb.fill < CAP) send(FUNC_INSERT, $urandom, pick_value());
    for (int i = 0; i < 10; i++) begin
      if (i % 3 == 0) send(FUNC_INSERT, present_key(), pick_value());
      else send(FUNC_INSERT, $urandom, pick_value());
    end
    send(FUNC_INSERT, KEY_MIN, 0);
    send(FUNC_INSERT, KEY_MAX, '1);
    for (int i = 0; i < 10; i++)
      send(FUNC_LOOKUP, (i % 2 == 0) ? present_key() : $urandom, $urandom);
    send(FUNC_SPARE, present_key(), $urandom);

    // shrink it again, back to back
    burst_mode = 1;
    for (int i = 0; i < 45; i++)
      send(FUNC_REMOVE, ($urandom_range(0, 4) != 0) ? present_key() : $urandom, $urandom);
    burst_mode = 0;
    drain();

    // more mixed traffic, then empty the table completely
    for (int i = 0; i < 80; i++) send_mixed();
    while (sb.fill > 0) send(FUNC_REMOVE, present_key(), $urandom);
    send(FUNC_LOOKUP, present_key(), 0);
    send(FUNC_REMOVE, pool_key(), 0);

    // noise: any code, any key
    for (int i = 0; i < 50; i++) begin
      if ($urandom_range(0, 1) == 1) send(FUNC_W'($urandom), $urandom, $urandom);
      else send_mixed();
    end

    drain();
    repeat (200) @(posedge clk);

    $display("covered %0d inserts, %0d lookups, %0d removes, %0d unused-code requests",
             sb.func_seen[FUNC_INSERT], sb.func_seen[FUNC_LOOKUP],
             sb.func_seen[FUNC_REMOVE], sb.func_seen[FUNC_SPARE]);
    $display("results: %0d ok, %0d duplicate, %0d missing, %0d full; peak fill %0d of %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_DUP], sb.status_seen[ST_MISS],
             sb.status_seen[ST_FULL], sb.peak_fill, CAP);
    if (sb.pending() != 0) begin
      $error("%0d results still due at end of run", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("sorted_key_value_table_core_tb: PASS");
    end else begin
      $display("sorted_key_value_table_core_tb: FAIL");
    end
    $finish;
  end

endmodule
